>>> hdl/bole_pkg.sv
// Package for the bounded ordered list engine.
// Holds field widths, command and status codes, and the control structs.
// No dependencies.
package bole_pkg;

	localparam int CMD_W       = 3;
	localparam int VAL_W       = 32;
	localparam int POS_W       = 7;
	localparam int LEN_W       = 7;
	localparam int ST_W        = 2;
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 48;

	// Command codes carried in the lowest bits of the input tdata.
	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND  = 3'd0,
		CMD_INSERT  = 3'd1,
		CMD_REMOVE  = 3'd2,
		CMD_REPLACE = 3'd3,
		CMD_READ    = 3'd4,
		CMD_COMPARE = 3'd5,
		CMD_CLEAR   = 3'd6,
		CMD_RSVD    = 3'd7
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_EXEC,
		PH_OUT
	} phase_t;

	// Operation broadcast to every cell of the row.
	typedef struct packed {
		logic ins;
		logic rem;
		logic wr;
	} cell_op_t;

	// Outcome of one command, handed from the controller to the output stage.
	typedef struct packed {
		logic             fire;
		status_t          status;
		logic [LEN_W-1:0] length;
		logic             is_empty;
		logic             is_full;
		logic             is_rd;
		logic             is_cmp;
	} exec_res_t;

endpackage

>>> hdl/bole_cell.sv
// One storage cell of the list row: holds a single entry.
// Takes its left or right neighbor on insert or remove, or the new value.
// Depends on bole_pkg.
module bole_cell
	import bole_pkg::*;
#(
	parameter int DATA_WIDTH = 32,
	parameter int IDX        = 0
) (
	input  logic                  clk,
	input  cell_op_t              op,
	input  logic [POS_W-1:0]      tgt,
	input  logic [DATA_WIDTH-1:0] din,
	input  logic [DATA_WIDTH-1:0] left,
	input  logic [DATA_WIDTH-1:0] right,
	output logic [DATA_WIDTH-1:0] entry,
	output logic [DATA_WIDTH-1:0] tap
);

	localparam logic [31:0] IDX_V = 32'(IDX);

	logic [DATA_WIDTH-1:0] entry_q;
	logic                  hit;
	logic                  above;

	// Position of this cell relative to the addressed index.
	assign hit   = (IDX_V == {{(32-POS_W){1'b0}}, tgt});
	assign above = (IDX_V >  {{(32-POS_W){1'b0}}, tgt});

	// Entry update: shift up on insert, shift down on remove, or overwrite.
	always_ff @(posedge clk) begin
		if (op.ins) begin
			if (above) begin
				entry_q <= left;
			end else if (hit) begin
				entry_q <= din;
			end
		end else if (op.rem) begin
			if (above || hit) begin
				entry_q <= right;
			end
		end else if (op.wr && hit) begin
			entry_q <= din;
		end
	end

	assign entry = entry_q;
	// The addressed cell places its entry on the read bus; others give zero.
	assign tap   = hit ? entry_q : '0;

endmodule

>>> hdl/bole_ctrl.sv
// Controller of the list engine: command register, phase sequencer, length,
// capacity register and the decision of each command. Depends on bole_pkg.
module bole_ctrl
	import bole_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  cmd_t             cmd_in,
	input  logic [VAL_W-1:0] val_in,
	input  logic [POS_W-1:0] pos_in,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [LEN_W-1:0] cfg_data,
	input  logic             out_taken,
	output cell_op_t         op,
	output logic [POS_W-1:0] tgt,
	output logic [VAL_W-1:0] val,
	output exec_res_t        res
);

	// Largest capacity that both the row and the register width allow.
	localparam int DCAP = (DEPTH > 127) ? 127 : DEPTH;

	phase_t           phase_q;
	phase_t           phase_nxt;
	cmd_t             cmd_q;
	logic [VAL_W-1:0] val_q;
	logic [POS_W-1:0] pos_q;
	logic [LEN_W-1:0] length_q;
	logic [LEN_W-1:0] len_nxt;
	logic [LEN_W-1:0] max_q;
	logic [LEN_W-1:0] cap;
	logic             full_now;
	logic             rng_rd;
	logic             rng_ins;
	logic             exec;
	status_t          status;
	cell_op_t         op_d;
	logic [POS_W-1:0] tgt_d;
	logic             rd_ok;
	logic             cmp_ok;

	assign cfg_ready = 1'b1;
	assign in_ready  = (phase_q == PH_IDLE);
	assign exec      = (phase_q == PH_EXEC);

	// Phase register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_nxt;
		end
	end

	// Next phase: accept, execute, then hold until the result is taken.
	always_comb begin
		phase_nxt = phase_q;
		unique case (phase_q)
			PH_IDLE: if (in_valid) begin
				phase_nxt = PH_EXEC;
			end
			PH_EXEC: phase_nxt = PH_OUT;
			PH_OUT: if (out_taken) begin
				phase_nxt = PH_IDLE;
			end
			default: phase_nxt = PH_IDLE;
		endcase
	end

	// Command register, loaded on each input transfer.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q <= cmd_in;
			val_q <= val_in;
			pos_q <= pos_in;
		end
	end

	// Capacity register and list length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q    <= LEN_W'(64);
			length_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				max_q <= cfg_data;
			end
			if (exec) begin
				length_q <= len_nxt;
			end
		end
	end

	assign cap      = (max_q > LEN_W'(DCAP)) ? LEN_W'(DCAP) : max_q;
	assign full_now = (length_q >= cap);
	assign rng_rd   = ({1'b0, pos_q} <  {1'b0, length_q});
	assign rng_ins  = ({1'b0, pos_q} <= {1'b0, length_q});

	// Command decision: status, cell operation and new length.
	always_comb begin
		status  = ST_OK;
		op_d    = '0;
		tgt_d   = pos_q;
		len_nxt = length_q;
		rd_ok   = 1'b0;
		cmp_ok  = 1'b0;
		unique case (cmd_q)
			CMD_APPEND: begin
				tgt_d = POS_W'(length_q);
				if (full_now) begin
					status = ST_FULL;
				end else begin
					op_d.wr = 1'b1;
					len_nxt = length_q + 1'b1;
				end
			end
			CMD_INSERT: begin
				if (!rng_ins) begin
					status = ST_RANGE;
				end else if (full_now) begin
					status = ST_FULL;
				end else begin
					op_d.ins = 1'b1;
					len_nxt  = length_q + 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (!rng_rd) begin
					status = ST_RANGE;
				end else begin
					op_d.rem = 1'b1;
					len_nxt  = length_q - 1'b1;
				end
			end
			CMD_REPLACE: begin
				if (!rng_rd) begin
					status = ST_RANGE;
				end else begin
					op_d.wr = 1'b1;
				end
			end
			CMD_READ: begin
				if (!rng_rd) begin
					status = ST_RANGE;
				end else begin
					rd_ok = 1'b1;
				end
			end
			CMD_COMPARE: begin
				if (!rng_rd) begin
					status = ST_RANGE;
				end else begin
					cmp_ok = 1'b1;
				end
			end
			CMD_CLEAR: len_nxt = '0;
			CMD_RSVD: begin
			end
			default: begin
			end
		endcase
	end

	// Cells act only in the execute cycle.
	assign op           = exec ? op_d : '0;
	assign tgt          = tgt_d;
	assign val          = val_q;
	assign res.fire     = exec;
	assign res.status   = status;
	assign res.length   = len_nxt;
	assign res.is_empty = (len_nxt == '0);
	assign res.is_full  = (len_nxt >= cap);
	assign res.is_rd    = rd_ok;
	assign res.is_cmp   = cmp_ok;

endmodule

>>> hdl/bounded_ordered_list_engine_unit.sv
// Top level of the bounded ordered list engine: controller, row of cells and
// output register. Depends on bole_pkg, bole_ctrl and bole_cell.
//
// Usage:
//   Commands enter on the s_ channel (s_tvalid, s_tready, s_tdata); each gives
//   exactly one result on the m_ channel (m_tvalid, m_tready, m_tdata).
//   The capacity register is written on cfg_valid/cfg_data; cfg_ready is
//   always high and a write should only be made while no command is in flight.
//   A command is taken, then executed in the cycle after the input transfer
//   (all cells shift or write at once), and its result is registered at the
//   end of the execute cycle, which raises m_tvalid.
//   One command is in flight at a time: s_tready returns high in the cycle
//   after the result transfer, so no new command is taken before the last
//   result is taken. This is set by the single command register that the
//   controller holds until its result is taken.
//   While the receiver stalls, the result holds steady and s_tready stays low.
//   Reset empties the list and sets the capacity to 64; stored entries are
//   not cleared, since only entries below the length are ever read.
module bounded_ordered_list_engine_unit
	import bole_pkg::*;
#(
	parameter int DEPTH      = 64,
	parameter int DATA_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// [2:0] cmd, [34:3] element_value, [41:35] position, [47:42] zero
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// [1:0] status, [33:2] read_value, [34] is_equal, [41:35] list_length,
	// [42] is_empty, [43] is_full, [47:44] zero
	output logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [LEN_W-1:0]       cfg_data
);

	cell_op_t              op;
	logic [POS_W-1:0]      tgt;
	logic [VAL_W-1:0]      val;
	exec_res_t             res;
	logic [DATA_WIDTH-1:0] din;
	logic [DATA_WIDTH-1:0] entry [DEPTH];
	logic [DATA_WIDTH-1:0] tap   [DEPTH];
	logic [DATA_WIDTH-1:0] sel_entry;
	logic                  m_tvalid_q;
	status_t               status_q;
	logic [VAL_W-1:0]      rd_q;
	logic                  eq_q;
	logic [LEN_W-1:0]      len_q;
	logic                  empty_q;
	logic                  full_q;

	bole_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.cmd_in   (cmd_t'(s_tdata[2:0])),
		.val_in   (s_tdata[34:3]),
		.pos_in   (s_tdata[41:35]),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.out_taken(m_tvalid_q && m_tready),
		.op       (op),
		.tgt      (tgt),
		.val      (val),
		.res      (res)
	);

	// Element masked to the stored width.
	assign din = DATA_WIDTH'(val);

	// Row of cells; each neighbor link carries one entry.
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left;
		logic [DATA_WIDTH-1:0] right;
		if (i == 0) begin : g_first
			assign left = '0;
		end else begin : g_mid_l
			assign left = entry[i-1];
		end
		if (i == DEPTH - 1) begin : g_last
			assign right = '0;
		end else begin : g_mid_r
			assign right = entry[i+1];
		end
		bole_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.IDX       (i)
		) u_cell (
			.clk  (clk),
			.op   (op),
			.tgt  (tgt),
			.din  (din),
			.left (left),
			.right(right),
			.entry(entry[i]),
			.tap  (tap[i])
		);
	end

	// Read bus: only the addressed cell drives a nonzero tap.
	always_comb begin
		sel_entry = '0;
		for (int i = 0; i < DEPTH; i++) begin
			sel_entry = sel_entry | tap[i];
		end
	end

	// Output valid: set by the execute cycle, cleared by the result transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res.fire) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (res.fire) begin
			status_q <= res.status;
			rd_q     <= res.is_rd ? VAL_W'(sel_entry) : '0;
			eq_q     <= res.is_cmp && (sel_entry == din);
			len_q    <= res.length;
			empty_q  <= res.is_empty;
			full_q   <= res.is_full;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {4'b0, full_q, empty_q, len_q, eq_q, rd_q, status_q};

endmodule
